### rtl/pftd_pkg.sv
package pftd_pkg;

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    // Which kind of trial divisor is currently in use.
    typedef enum logic [1:0] {
        K_TWO   = 2'd0,
        K_THREE = 2'd1,
        K_LO    = 2'd2,
        K_HI    = 2'd3
    } t_dkind;

    // Status of the bit-serial divider.
    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_div_sts;

    // Control and status of the divisor-squared tracker.
    typedef struct packed {
        logic init;
        logic step;
    } t_sq_ctl;

    typedef struct packed {
        logic fits_first;
        logic fits_next;
    } t_sq_sts;

    localparam int DIV_FIRST   = 2;
    localparam int DIV_SECOND  = 3;
    localparam int PAIR_FIRST  = 5;
    localparam int PAIR_STRIDE = 6;
    localparam int PAIR_GAP    = 2;

    // Square of the first pair divisor and its increments:
    // (d+6)^2 = d^2 + (12d + 36), and the increment itself grows by 72.
    localparam int SQ_FIRST  = PAIR_FIRST * PAIR_FIRST;
    localparam int INC_FIRST = 2 * PAIR_STRIDE * PAIR_FIRST + PAIR_STRIDE * PAIR_STRIDE;
    localparam int INC_STEP  = 2 * PAIR_STRIDE * PAIR_STRIDE;

    // Extra bits on the square so it never wraps before it passes the remainder.
    localparam int SQ_EXTRA = 4;

endpackage

### rtl/pftd_div.sv
module pftd_div
    import pftd_pkg::*;
#(
    parameter int W = 31
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic [W-1:0] o_quotient,
    output t_div_sts     o_sts
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_q;
    logic [W-1:0]  r_pr;
    logic [W-1:0]  r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_run;
    logic          r_done;

    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic          ge;

    // One quotient bit per cycle, restoring form.
    assign shifted = {r_pr, r_q[W-1]};
    assign ge      = shifted >= {1'b0, r_dvs};
    assign diff    = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == CW'(1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_pr  <= '0;
            r_dvs <= i_divisor;
            r_cnt <= CW'(W);
        end else if (r_run) begin
            r_q   <= {r_q[W-2:0], ge};
            r_pr  <= ge ? diff[W-1:0] : shifted[W-1:0];
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign o_quotient     = r_q;
    assign o_sts.done     = r_done;
    assign o_sts.rem_zero = (r_pr == '0);

endmodule

### rtl/pftd_sq.sv
module pftd_sq
    import pftd_pkg::*;
#(
    parameter int W = 31
) (
    input  logic         i_clk,
    input  t_sq_ctl      i_ctl,
    input  logic [W-1:0] i_rem,
    output t_sq_sts      o_sts
);

    localparam int SW = W + SQ_EXTRA;

    logic [SW-1:0] r_sq;
    logic [SW-1:0] r_inc;
    logic [SW-1:0] sq_next;
    logic [SW-1:0] rem_ext;

    // Square of the pair divisor, kept by running sums instead of a multiplier.
    assign sq_next = r_sq + r_inc;
    assign rem_ext = {{SQ_EXTRA{1'b0}}, i_rem};

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_sq  <= SW'(SQ_FIRST);
            r_inc <= SW'(INC_FIRST);
        end else if (i_ctl.step) begin
            r_sq  <= sq_next;
            r_inc <= r_inc + SW'(INC_STEP);
        end
    end

    assign o_sts.fits_first = SW'(SQ_FIRST) <= rem_ext;
    assign o_sts.fits_next  = sq_next <= rem_ext;

endmodule

### rtl/prime_factorizer_trial_division_core.sv
// Channel   Direction  Handshake             Payload
// request   in         start high, busy low  i_number
// result    out        o_strobe, one cycle   o_factor, o_last
//
// Each trial division runs through a bit-serial divider, one quotient bit per
// cycle. The work for a number grows with the number of trials: the runs of
// 2 and 3, two trials per 6k-1/6k+1 pair up to the square root of what
// remains, and one per factor found, before the final results are flushed.
// Reset is synchronous and active low and returns the block to idle. Results
// cannot be stalled by the receiver, so the block never waits on the output.
module prime_factorizer_trial_division_core
    import pftd_pkg::*;
#(
    parameter int VALUE_BITS = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] i_number,
    output logic                  busy,
    output logic                  o_strobe,
    output logic [VALUE_BITS-1:0] o_factor,
    output logic                  o_last
);

    localparam int W = VALUE_BITS;

    t_state        r_state, n_state;
    t_dkind        r_kind,  n_kind;
    logic [W-1:0]  r_rem,   n_rem;
    logic [W-1:0]  r_cd,    n_cd;
    logic [W-1:0]  r_pend,  n_pend;
    logic          r_pend_v, n_pend_v;
    logic          r_strobe, n_strobe;
    logic [W-1:0]  r_factor, n_factor;
    logic          r_last,   n_last;

    logic          div_start;
    logic [W-1:0]  quotient;
    t_div_sts      div_sts;
    t_sq_ctl       sq_ctl;
    t_sq_sts       sq_sts;

    // The divider always works on the next remainder and the next divisor, so
    // a new trial can be launched in the same cycle that the last one ends.
    pftd_div #(
        .W (W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_rem),
        .i_divisor  (n_cd),
        .o_quotient (quotient),
        .o_sts      (div_sts)
    );

    // Tracks the square of the divisor that opens the current pair.
    pftd_sq #(
        .W (W)
    ) u_sq (
        .i_clk (i_clk),
        .i_ctl (sq_ctl),
        .i_rem (r_rem),
        .o_sts (sq_sts)
    );

    // A found factor is held back as pending until the next one shows up or
    // the number is done; only then is it known whether it is the last one.
    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_rem     = r_rem;
        n_cd      = r_cd;
        n_pend    = r_pend;
        n_pend_v  = r_pend_v;
        n_strobe  = 1'b0;
        n_factor  = r_factor;
        n_last    = 1'b0;
        div_start = 1'b0;
        sq_ctl    = '0;

        case (r_state)
            S_IDLE: begin
                if (start && i_number > W'(1)) begin
                    n_rem     = i_number;
                    n_cd      = W'(DIV_FIRST);
                    n_kind    = K_TWO;
                    n_pend_v  = 1'b0;
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end

            S_DIV: begin
                if (div_sts.done) begin
                    if (div_sts.rem_zero) begin
                        // Divisor hits: release the older factor, keep this one.
                        n_strobe  = r_pend_v;
                        n_factor  = r_pend;
                        n_pend    = r_cd;
                        n_pend_v  = 1'b1;
                        n_rem     = quotient;
                        div_start = 1'b1;
                    end else begin
                        case (r_kind)
                            K_TWO: begin
                                n_cd      = W'(DIV_SECOND);
                                n_kind    = K_THREE;
                                div_start = 1'b1;
                            end
                            K_THREE: begin
                                if (sq_sts.fits_first) begin
                                    n_cd        = W'(PAIR_FIRST);
                                    n_kind      = K_LO;
                                    sq_ctl.init = 1'b1;
                                    div_start   = 1'b1;
                                end else begin
                                    n_state = S_FIN;
                                end
                            end
                            K_LO: begin
                                // The upper member of a pair is tried unconditionally.
                                n_cd      = r_cd + W'(PAIR_GAP);
                                n_kind    = K_HI;
                                div_start = 1'b1;
                            end
                            K_HI: begin
                                if (sq_sts.fits_next) begin
                                    n_cd        = r_cd + W'(PAIR_STRIDE - PAIR_GAP);
                                    n_kind      = K_LO;
                                    sq_ctl.step = 1'b1;
                                    div_start   = 1'b1;
                                end else begin
                                    n_state = S_FIN;
                                end
                            end
                            default: begin
                                n_state = S_FIN;
                            end
                        endcase
                    end
                end
            end

            S_FIN: begin
                if (r_rem > W'(DIV_SECOND)) begin
                    // The leftover remainder is a prime larger than any trial
                    // divisor; it becomes the pending factor.
                    n_strobe = r_pend_v;
                    n_factor = r_pend;
                    n_pend   = r_rem;
                    n_pend_v = 1'b1;
                    n_rem    = W'(1);
                end else begin
                    n_strobe = 1'b1;
                    n_factor = r_pend;
                    n_last   = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kind   <= K_TWO;
            r_pend_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_kind   <= n_kind;
            r_pend_v <= n_pend_v;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_cd     <= n_cd;
        r_pend   <= n_pend;
        r_factor <= n_factor;
        r_last   <= n_last;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_factor = r_factor;
    assign o_last   = r_last;

endmodule

### rtl/pftd_chk.sv
module pftd_chk
    import pftd_pkg::*;
#(
    parameter int VALUE_BITS = 31
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic [VALUE_BITS-1:0] i_number,
    input logic                  busy,
    input logic                  o_strobe,
    input logic [VALUE_BITS-1:0] o_factor,
    input logic                  o_last
);

    // The final factor closes the request; every earlier one comes while busy.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> !busy)
        else $error("last factor delivered while still busy");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("non-final factor delivered after the request ended");

    a_factor_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_factor >= VALUE_BITS'(DIV_FIRST))
        else $error("factor below two delivered");

    a_trivial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_number <= VALUE_BITS'(1) |=> !busy && !o_strobe)
        else $error("zero or one did not complete silently");

    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_strobe && o_last)
        else $error("request ended without a final factor");

endmodule

bind prime_factorizer_trial_division_core pftd_chk #(
    .VALUE_BITS (VALUE_BITS)
) u_pftd_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_number (i_number),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_factor (o_factor),
    .o_last   (o_last)
);
